>>> rtl/olist_pkg.sv
// Shared types, codes and widths for the ordered list engine.
`default_nettype none

package olist_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 4;
    localparam int POS_W     = 6;
    localparam int ST_W      = 3;
    localparam int LEN_W     = 6;
    localparam int DEPTH_DEF = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_REVERSE   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_READ      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_READ_REV  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd9;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [ST_W-1:0] ST_FEW    = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [LEN_W-1:0]         length;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } t_out_item;

    // whole-chain operation
    typedef enum logic [2:0] {
        CH_HOLD,
        CH_INSERT,
        CH_DELETE,
        CH_ROT_DN,
        CH_ROT_UP
    } t_chain_op;

    // per-cell source select
    typedef enum logic [2:0] {
        C_HOLD,
        C_LEFT,
        C_RIGHT,
        C_VALUE,
        C_WRAP
    } t_cell_op;

    typedef struct packed {
        t_chain_op                op;
        logic signed [DATA_W-1:0] value;
    } t_chain_ctl;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

`default_nettype wire

>>> rtl/olist_cell.sv
// One storage cell of the element chain.
`default_nettype none

module olist_cell (
    input  wire                                 i_clk,
    input  wire olist_pkg::t_cell_op            i_op,
    input  wire logic signed [olist_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [olist_pkg::DATA_W-1:0] i_right,
    input  wire logic signed [olist_pkg::DATA_W-1:0] i_value,
    input  wire logic signed [olist_pkg::DATA_W-1:0] i_wrap,
    output logic signed [olist_pkg::DATA_W-1:0]      o_data
);

    logic signed [olist_pkg::DATA_W-1:0] r_data;
    logic signed [olist_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            olist_pkg::C_LEFT:  n_data = i_left;
            olist_pkg::C_RIGHT: n_data = i_right;
            olist_pkg::C_VALUE: n_data = i_value;
            olist_pkg::C_WRAP:  n_data = i_wrap;
            default:            n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> rtl/olist_chain.sv
// Row of element cells with per-cell shift control and head/tail taps.
`default_nettype none

module olist_chain #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
    input  wire                                   i_clk,
    input  wire olist_pkg::t_chain_ctl            i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]       i_pos,
    input  wire logic [$clog2(DEPTH+1)-1:0]       i_len,
    output logic signed [olist_pkg::DATA_W-1:0]   o_head,
    output logic signed [olist_pkg::DATA_W-1:0]   o_tail
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [olist_pkg::DATA_W-1:0] w_data [DEPTH];
    logic signed [olist_pkg::DATA_W-1:0] w_wrap;
    logic [CW-1:0]                       w_len_m1;
    logic [IW-1:0]                       w_tail_idx;

    assign w_len_m1   = i_len - CW'(1);
    assign w_tail_idx = w_len_m1[IW-1:0];
    assign o_head     = w_data[0];
    assign o_tail     = w_data[w_tail_idx];
    // head feeds the tail on a downward rotate, tail feeds the head going up
    assign w_wrap     = (i_ctl.op == olist_pkg::CH_ROT_UP) ? o_tail : o_head;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(gi);

        olist_pkg::t_cell_op                 w_op;
        logic signed [olist_pkg::DATA_W-1:0] w_left;
        logic signed [olist_pkg::DATA_W-1:0] w_right;

        if (gi == 0) begin : g_first
            assign w_left = w_wrap;
        end else begin : g_mid_l
            assign w_left = w_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_end
            assign w_right = w_data[gi];
        end else begin : g_mid_r
            assign w_right = w_data[gi+1];
        end

        always_comb begin
            case (i_ctl.op)
                olist_pkg::CH_INSERT: begin
                    if (IDX == i_pos)     w_op = olist_pkg::C_VALUE;
                    else if (IDX > i_pos) w_op = olist_pkg::C_LEFT;
                    else                  w_op = olist_pkg::C_HOLD;
                end
                olist_pkg::CH_DELETE: begin
                    w_op = (IDX >= i_pos) ? olist_pkg::C_RIGHT : olist_pkg::C_HOLD;
                end
                olist_pkg::CH_ROT_DN: begin
                    if (IDX == w_len_m1)     w_op = olist_pkg::C_WRAP;
                    else if (IDX < w_len_m1) w_op = olist_pkg::C_RIGHT;
                    else                     w_op = olist_pkg::C_HOLD;
                end
                olist_pkg::CH_ROT_UP: begin
                    w_op = (IDX == '0) ? olist_pkg::C_WRAP : olist_pkg::C_LEFT;
                end
                default: w_op = olist_pkg::C_HOLD;
            endcase
        end

        olist_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_left  (w_left),
            .i_right (w_right),
            .i_value (i_ctl.value),
            .i_wrap  (w_wrap),
            .o_data  (w_data[gi])
        );
    end

endmodule

`default_nettype wire

>>> rtl/ordered_list_engine.sv
// Ordered list engine: top level with command decode, read sequencer and result register.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in_data  (command, value, position)
//  out     | out | o_out_valid / i_out_ready | o_out_data (status, length, element, last)
//
// Edits, reverse and count: one result transfer each; only edits act on the chain.
// Reads: enter the read state, then one element per cycle over the length while the
// output is free, each rotating the chain one cell so it is back in place after the last.
// Reset (synchronous, i_rst_n low) empties the list; cell contents are not cleared.
// A stalled result holds the output register and the read sequencer; a new command
// is taken only when the sequencer is idle and the result register is free or draining.
`default_nettype none

module ordered_list_engine #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire olist_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output olist_pkg::t_out_item  o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;

    // Reverse is logical: r_rev flips the mapping between list index and cell,
    // so physical cell k holds list entry k (r_rev low) or length-1-k (r_rev high).
    olist_pkg::t_state    r_state, n_state;
    logic [CW-1:0]        r_len, n_len;
    logic                 r_rev, n_rev;
    logic                 r_up, n_up;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_out_valid;
    olist_pkg::t_out_item r_out_data;
    olist_pkg::t_out_item n_out_data;
    logic                 n_out_load;

    olist_pkg::t_chain_ctl                 w_ctl;
    logic [CW-1:0]                         w_phys;
    logic signed [olist_pkg::DATA_W-1:0]   w_head, w_tail;

    logic             w_out_free, w_in_fire, w_empty, w_full, w_is_read, w_read_go;
    logic [XW-1:0]    w_lenx, w_posx, w_ins_p, w_del_p;
    logic [CW-1:0]    w_ins_phys, w_del_phys;
    logic [olist_pkg::CMD_W-1:0] w_cmd;

    assign w_cmd      = i_in_data.command;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == olist_pkg::S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_empty    = (r_len == '0);
    assign w_full     = (r_len == CW'(DEPTH));
    assign w_is_read  = (w_cmd == olist_pkg::CMD_READ) || (w_cmd == olist_pkg::CMD_READ_REV);
    assign w_read_go  = w_in_fire && w_is_read && !w_empty;

    assign w_lenx = XW'(r_len);
    assign w_posx = XW'(i_in_data.position);

    // logical insert/delete positions, then mapped to a cell index
    always_comb begin
        case (w_cmd)
            olist_pkg::CMD_INS_FRONT: w_ins_p = '0;
            olist_pkg::CMD_INS_BACK:  w_ins_p = w_lenx;
            default:                  w_ins_p = w_posx;
        endcase
        case (w_cmd)
            olist_pkg::CMD_DEL_FRONT: w_del_p = '0;
            olist_pkg::CMD_DEL_BACK:  w_del_p = w_lenx - XW'(1);
            default:                  w_del_p = w_posx;
        endcase
    end

    assign w_ins_phys = r_rev ? CW'(w_lenx - w_ins_p) : CW'(w_ins_p);
    assign w_del_phys = r_rev ? CW'(w_lenx - XW'(1) - w_del_p) : CW'(w_del_p);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            olist_pkg::S_IDLE: if (w_read_go) n_state = olist_pkg::S_READ;
            olist_pkg::S_READ: if (w_out_free && r_left == CW'(1)) n_state = olist_pkg::S_IDLE;
            default:           n_state = olist_pkg::S_IDLE;
        endcase
    end

    // datapath control and result build
    always_comb begin
        n_len      = r_len;
        n_rev      = r_rev;
        n_up       = r_up;
        n_left     = r_left;
        n_out_load = 1'b0;
        w_ctl.op   = olist_pkg::CH_HOLD;
        w_ctl.value = i_in_data.value;
        w_phys     = '0;
        n_out_data.status  = olist_pkg::ST_OK;
        n_out_data.element = '0;
        n_out_data.last    = 1'b1;

        case (r_state)
            olist_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_out_load = 1'b1;
                    case (w_cmd)
                        olist_pkg::CMD_INS_FRONT,
                        olist_pkg::CMD_INS_BACK,
                        olist_pkg::CMD_INS_AT: begin
                            if (w_full) begin
                                n_out_data.status = olist_pkg::ST_FULL;
                            end else if (w_ins_p > w_lenx) begin
                                n_out_data.status = olist_pkg::ST_BADPOS;
                            end else begin
                                w_ctl.op = olist_pkg::CH_INSERT;
                                w_phys   = w_ins_phys;
                                n_len    = r_len + CW'(1);
                            end
                        end
                        olist_pkg::CMD_DEL_FRONT,
                        olist_pkg::CMD_DEL_BACK,
                        olist_pkg::CMD_DEL_AT: begin
                            if (w_empty) begin
                                n_out_data.status = olist_pkg::ST_EMPTY;
                            end else if (w_del_p >= w_lenx) begin
                                n_out_data.status = olist_pkg::ST_BADPOS;
                            end else begin
                                w_ctl.op = olist_pkg::CH_DELETE;
                                w_phys   = w_del_phys;
                                n_len    = r_len - CW'(1);
                            end
                        end
                        olist_pkg::CMD_REVERSE: begin
                            if (r_len < CW'(2)) n_out_data.status = olist_pkg::ST_FEW;
                            else                n_rev = !r_rev;
                        end
                        olist_pkg::CMD_READ,
                        olist_pkg::CMD_READ_REV: begin
                            if (w_empty) begin
                                n_out_data.status = olist_pkg::ST_EMPTY;
                            end else begin
                                // elements go out from the read state
                                n_out_load = 1'b0;
                                n_up   = (w_cmd == olist_pkg::CMD_READ_REV) ^ r_rev;
                                n_left = r_len;
                            end
                        end
                        default: ;  // count and unused codes: plain ok result
                    endcase
                end
            end
            olist_pkg::S_READ: begin
                if (w_out_free) begin
                    n_out_load         = 1'b1;
                    n_out_data.element = r_up ? w_tail : w_head;
                    n_out_data.last    = (r_left == CW'(1));
                    w_ctl.op           = r_up ? olist_pkg::CH_ROT_UP : olist_pkg::CH_ROT_DN;
                    n_left             = r_left - CW'(1);
                end
            end
            default: ;
        endcase
        n_out_data.length = olist_pkg::LEN_W'(n_len);
    end

    olist_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_pos  (w_phys),
        .i_len  (r_len),
        .o_head (w_head),
        .o_tail (w_tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olist_pkg::S_IDLE;
            r_len       <= '0;
            r_rev       <= 1'b0;
            r_up        <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_rev   <= n_rev;
            r_up    <= n_up;
            r_left  <= n_left;
            if (n_out_load)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/olist_checker.sv
// Port-level assertions for the ordered list engine, bound to the top level.
`default_nettype none

module olist_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input wire olist_pkg::t_in_item  i_in_data,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire olist_pkg::t_out_item o_out_data
);

    // a waiting command holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("command changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no command is taken while a result is blocked
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid || i_out_ready)
        else $error("input ready while output blocked");

    // mid-read transfers keep the input closed
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |-> !o_in_ready)
        else $error("command taken in the middle of a read");

    // refused results are single and carry no element
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != olist_pkg::ST_OK
            |-> o_out_data.last && o_out_data.element == '0)
        else $error("error result not final or has element");

endmodule

bind ordered_list_engine olist_checker u_olist_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

>>> dv/tb_ordered_list_engine.sv
// Self-checking testbench for the ordered list engine, with a shadow list predictor.
`timescale 1ns / 1ps

module tb_ordered_list_engine;

    localparam int CLK_PERIOD = 12;
    localparam int LIST_DEPTH = olist_pkg::DEPTH_DEF;
    // Worst case is far below this: every read at full length under heavy stalls.
    localparam int TIMEOUT_CYCLES = 400_000;
    // Cycles to watch the output after the last awaited result.
    localparam int SETTLE_CYCLES = 8;

    // Codes 10..15 carry no operation; the block answers them like a count.
    localparam logic [olist_pkg::CMD_W-1:0] CMD_UNUSED_LO =
        olist_pkg::CMD_COUNT + olist_pkg::CMD_W'(1);
    localparam logic [olist_pkg::CMD_W-1:0] CMD_UNUSED_HI = '1;

    localparam logic signed [olist_pkg::DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [olist_pkg::DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    olist_pkg::t_in_item  i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    olist_pkg::t_out_item o_out_data;

    // Shadow copy of the list: contents, fill level, and the replies still owed.
    logic signed [olist_pkg::DATA_W-1:0] shadow_list [$];
    int                                  shadow_len;
    olist_pkg::t_out_item                awaited_replies [$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    ordered_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one accepted command to the shadow list and queue
    // every reply it should produce, in order.
    // ------------------------------------------------------------------
    function automatic void push_reply(input logic [olist_pkg::ST_W-1:0] st,
                                       input logic signed [olist_pkg::DATA_W-1:0] elem,
                                       input logic is_last);
        olist_pkg::t_out_item reply;
        reply.status  = st;
        reply.length  = olist_pkg::LEN_W'(shadow_len);
        reply.element = elem;
        reply.last    = is_last;
        awaited_replies.push_back(reply);
    endfunction

    function automatic void apply_list_command(input olist_pkg::t_in_item cmd);
        logic [olist_pkg::ST_W-1:0]          st;
        int                                  slot;
        int                                  lo;
        int                                  hi;
        logic signed [olist_pkg::DATA_W-1:0] swap;
        st = olist_pkg::ST_OK;
        case (cmd.command)
            olist_pkg::CMD_INS_FRONT, olist_pkg::CMD_INS_BACK, olist_pkg::CMD_INS_AT: begin
                // full is checked ahead of the position
                if (shadow_len >= LIST_DEPTH) begin
                    st = olist_pkg::ST_FULL;
                end else begin
                    if (cmd.command == olist_pkg::CMD_INS_FRONT)
                        slot = 0;
                    else if (cmd.command == olist_pkg::CMD_INS_BACK)
                        slot = shadow_len;
                    else
                        slot = int'(cmd.position);
                    if (slot > shadow_len) begin
                        st = olist_pkg::ST_BADPOS;
                    end else begin
                        shadow_list.insert(slot, cmd.value);
                        shadow_len++;
                    end
                end
            end
            olist_pkg::CMD_DEL_FRONT, olist_pkg::CMD_DEL_BACK, olist_pkg::CMD_DEL_AT: begin
                // empty is checked ahead of the position
                if (shadow_len == 0) begin
                    st = olist_pkg::ST_EMPTY;
                end else begin
                    if (cmd.command == olist_pkg::CMD_DEL_FRONT)
                        slot = 0;
                    else if (cmd.command == olist_pkg::CMD_DEL_BACK)
                        slot = shadow_len - 1;
                    else
                        slot = int'(cmd.position);
                    if (slot >= shadow_len) begin
                        st = olist_pkg::ST_BADPOS;
                    end else begin
                        shadow_list.delete(slot);
                        shadow_len--;
                    end
                end
            end
            olist_pkg::CMD_REVERSE: begin
                if (shadow_len < 2) begin
                    st = olist_pkg::ST_FEW;
                end else begin
                    lo = 0;
                    hi = shadow_len - 1;
                    while (lo < hi) begin
                        swap            = shadow_list[lo];
                        shadow_list[lo] = shadow_list[hi];
                        shadow_list[hi] = swap;
                        lo++;
                        hi--;
                    end
                end
            end
            olist_pkg::CMD_READ, olist_pkg::CMD_READ_REV: begin
                if (shadow_len == 0) begin
                    push_reply(olist_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        slot = (cmd.command == olist_pkg::CMD_READ) ? i : shadow_len - 1 - i;
                        push_reply(olist_pkg::ST_OK, shadow_list[slot], i + 1 == shadow_len);
                    end
                end
                return;
            end
            default: st = olist_pkg::ST_OK;  // count and unused codes
        endcase
        push_reply(st, '0, 1'b1);
    endfunction

    function automatic olist_pkg::t_in_item make_item(
        input logic [olist_pkg::CMD_W-1:0]          command,
        input logic signed [olist_pkg::DATA_W-1:0] value,
        input logic [olist_pkg::POS_W-1:0]          position);
        olist_pkg::t_in_item it;
        it.command  = command;
        it.value    = value;
        it.position = position;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle gap, then hold valid until the transfer.
    // Valid is left high after a transfer so back-to-back items stream; it
    // only drops for a gap or when the sequence is done.
    // ------------------------------------------------------------------
    task automatic send_command(input olist_pkg::t_in_item cmd);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        apply_list_command(cmd);
    endtask

    // Receiver backpressure, redrawn every cycle.
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Result checker: every output transfer must match the oldest reply owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        olist_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_replies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result status=%0d length=%0d element=%0d last=%0d",
                         $time, o_out_data.status, o_out_data.length,
                         o_out_data.element, o_out_data.last);
            end else begin
                want = awaited_replies.pop_front();
                if (o_out_data.status !== want.status || o_out_data.length !== want.length
                    || o_out_data.element !== want.element
                    || o_out_data.last !== want.last) begin
                    error_count++;
                    $display({"%0t: mismatch expected status=%0d length=%0d element=%0d ",
                              "last=%0d, actual status=%0d length=%0d element=%0d last=%0d"},
                             $time, want.status, want.length, want.element, want.last,
                             o_out_data.status, o_out_data.length, o_out_data.element,
                             o_out_data.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic signed [olist_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-range positions; a quarter anywhere in the 6-bit field.
    function automatic logic [olist_pkg::POS_W-1:0] random_position();
        if ($urandom_range(3) == 0)
            return olist_pkg::POS_W'($urandom_range(0, 63));
        return olist_pkg::POS_W'($urandom_range(0, shadow_len));
    endfunction

    // Inserts are favored while the list is short and cut back while it is long,
    // so the fill level wanders over the whole range.
    function automatic olist_pkg::t_in_item random_command();
        olist_pkg::t_in_item it;
        int                  ins_pct;
        int                  roll;
        it.value    = random_value();
        it.position = random_position();
        ins_pct     = (shadow_len < 8) ? 60 : (shadow_len > 24) ? 25 : 40;
        roll        = $urandom_range(99);
        if (roll < ins_pct) begin
            case ($urandom_range(2))
                0:       it.command = olist_pkg::CMD_INS_FRONT;
                1:       it.command = olist_pkg::CMD_INS_BACK;
                default: it.command = olist_pkg::CMD_INS_AT;
            endcase
        end else if (roll < ins_pct + 25) begin
            case ($urandom_range(2))
                0:       it.command = olist_pkg::CMD_DEL_FRONT;
                1:       it.command = olist_pkg::CMD_DEL_BACK;
                default: it.command = olist_pkg::CMD_DEL_AT;
            endcase
        end else begin
            roll = $urandom_range(99);
            if (roll < 25)
                it.command = olist_pkg::CMD_REVERSE;
            else if (roll < 55)
                it.command = olist_pkg::CMD_READ;
            else if (roll < 85)
                it.command = olist_pkg::CMD_READ_REV;
            else if (roll < 93)
                it.command = olist_pkg::CMD_COUNT;
            else
                it.command = olist_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        return it;
    endfunction

    // Every refusal an empty list can give, plus count and an unused code.
    task automatic test_empty_list();
        send_command(make_item(olist_pkg::CMD_READ,      '0, '0));
        send_command(make_item(olist_pkg::CMD_READ_REV,  '0, '0));
        send_command(make_item(olist_pkg::CMD_DEL_FRONT, '0, '0));
        send_command(make_item(olist_pkg::CMD_DEL_BACK,  '0, '0));
        send_command(make_item(olist_pkg::CMD_DEL_AT,    '0, '1));  // empty wins over bad position
        send_command(make_item(olist_pkg::CMD_REVERSE,   '0, '0));
        send_command(make_item(olist_pkg::CMD_COUNT,     '0, '0));
        send_command(make_item(CMD_UNUSED_HI,            '0, '0));
    endtask

    // Each edit and read on a short list with extreme values, including
    // position at the length (append vs. out of range) and one-element reverse.
    task automatic test_edits_and_reads();
        send_command(make_item(olist_pkg::CMD_INS_FRONT, VALUE_MIN, '0));
        send_command(make_item(olist_pkg::CMD_REVERSE,   '0, '0));        // one element: too few
        send_command(make_item(olist_pkg::CMD_INS_BACK,  VALUE_MAX, '0));
        send_command(make_item(olist_pkg::CMD_INS_AT,    -32'sd1, 6'd1));
        send_command(make_item(olist_pkg::CMD_INS_AT,    '0, 6'd3));      // position == length appends
        send_command(make_item(olist_pkg::CMD_INS_AT,    32'sd5, 6'd5));  // beyond length
        send_command(make_item(olist_pkg::CMD_INS_AT,    32'sd6, '1));
        send_command(make_item(olist_pkg::CMD_READ,      '0, '0));
        send_command(make_item(olist_pkg::CMD_READ_REV,  '0, '0));
        send_command(make_item(olist_pkg::CMD_REVERSE,   '0, '0));
        send_command(make_item(olist_pkg::CMD_READ,      '0, '0));
        send_command(make_item(olist_pkg::CMD_DEL_AT,    '0, 6'd4));      // position == length
        send_command(make_item(olist_pkg::CMD_DEL_AT,    '0, '1));
        send_command(make_item(olist_pkg::CMD_DEL_AT,    '0, 6'd1));
        send_command(make_item(olist_pkg::CMD_DEL_FRONT, '0, '0));
        send_command(make_item(olist_pkg::CMD_DEL_BACK,  '0, '0));
        send_command(make_item(olist_pkg::CMD_COUNT,     '0, '0));
        send_command(make_item(CMD_UNUSED_LO,            '0, '0));
        send_command(make_item(olist_pkg::CMD_DEL_BACK,  '0, '0));        // last element goes
    endtask

    // Fill to capacity with random inserts, hit every full refusal, read the
    // full list both ways, then empty it again with random deletes.
    task automatic test_fill_and_overflow();
        olist_pkg::t_in_item it;
        while (shadow_len < LIST_DEPTH) begin
            it = random_command();
            it.command  = (it.value[0]) ? olist_pkg::CMD_INS_AT
                        : (it.value[1] ? olist_pkg::CMD_INS_BACK : olist_pkg::CMD_INS_FRONT);
            it.position = olist_pkg::POS_W'($urandom_range(0, shadow_len));
            send_command(it);
        end
        send_command(make_item(olist_pkg::CMD_INS_FRONT, random_value(), '0));
        send_command(make_item(olist_pkg::CMD_INS_BACK,  random_value(), '0));
        send_command(make_item(olist_pkg::CMD_INS_AT,    random_value(), '0));
        send_command(make_item(olist_pkg::CMD_INS_AT,    random_value(), '1));  // full wins
        send_command(make_item(olist_pkg::CMD_READ,      '0, '0));
        send_command(make_item(olist_pkg::CMD_READ_REV,  '0, '0));
        send_command(make_item(olist_pkg::CMD_REVERSE,   '0, '0));
        send_command(make_item(olist_pkg::CMD_READ,      '0, '0));
        send_command(make_item(olist_pkg::CMD_DEL_AT,    '0, 6'(LIST_DEPTH)));  // one past the end
        while (shadow_len > 0) begin
            case ($urandom_range(2))
                0:       it = make_item(olist_pkg::CMD_DEL_FRONT, '0, '0);
                1:       it = make_item(olist_pkg::CMD_DEL_BACK, '0, '0);
                default: it = make_item(olist_pkg::CMD_DEL_AT, '0,
                                        olist_pkg::POS_W'($urandom_range(0, shadow_len - 1)));
            endcase
            send_command(it);
        end
        send_command(make_item(olist_pkg::CMD_DEL_AT, '0, 6'd40));
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_command(random_command());
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed checks, then random traffic under each
    // idling mix; finally drain and watch for stray results.
    // ------------------------------------------------------------------
    initial begin
        shadow_len = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edits_and_reads();

        send_idle_pct  = 49;
        recv_stall_pct = 0;
        test_random_mix(35);

        send_idle_pct  = 0;
        recv_stall_pct = 49;
        test_random_mix(35);

        send_idle_pct  = 17;
        recv_stall_pct = 17;
        test_fill_and_overflow();
        test_random_mix(35);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_mix(25);

        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("ordered_list_engine test passed");
        else
            $display("ordered_list_engine test failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("ordered_list_engine test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/olist_pkg.sv
rtl/olist_cell.sv
rtl/olist_chain.sv
rtl/ordered_list_engine.sv
rtl/olist_checker.sv
dv/tb_ordered_list_engine.sv
